/* rtl/core/rasi_pkg.sv */
// Shared types for the 2D ray versus box slab test.
// Used by rasi_div_pipe and ray_aabb_slab_intersect_2d; depends on nothing.
package rasi_pkg;

    typedef struct packed {
        logic valid;
        logic neg;
    } div_tag_t;

endpackage

/* rtl/core/rasi_div_pipe.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage, with sign fixup.
// Depends on rasi_pkg for the tag that travels with each item.
module rasi_div_pipe
    import rasi_pkg::*;
#(
    parameter int NUM_W = 49,
    parameter int DEN_W = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  div_tag_t                in_tag,
    input  logic [NUM_W-1:0]        num,
    input  logic [DEN_W-1:0]        den,
    output div_tag_t                out_tag,
    output logic signed [NUM_W:0]   quo
);

    div_tag_t           tag_reg  [NUM_W];
    logic [DEN_W-1:0]   rem_reg  [NUM_W];
    logic [NUM_W-1:0]   nq_reg   [NUM_W];
    logic [DEN_W-1:0]   den_reg  [NUM_W];
    div_tag_t           tag_next [NUM_W];
    logic [DEN_W-1:0]   rem_next [NUM_W];
    logic [NUM_W-1:0]   nq_next  [NUM_W];
    logic [DEN_W-1:0]   den_next [NUM_W];
    div_tag_t           out_tag_reg;
    logic signed [NUM_W:0] quo_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_W; k++)
        begin
            logic [DEN_W:0]     trial;
            logic               ge;
            div_tag_t           s_tag;
            logic [DEN_W-1:0]   s_rem;
            logic [NUM_W-1:0]   s_nq;
            logic [DEN_W-1:0]   s_den;
            if (k == 0)
            begin
                s_tag = in_tag;
                s_rem = '0;
                s_nq  = num;
                s_den = den;
            end
            else
            begin
                s_tag = tag_reg[k-1];
                s_rem = rem_reg[k-1];
                s_nq  = nq_reg[k-1];
                s_den = den_reg[k-1];
            end
            trial = {s_rem, s_nq[NUM_W-1]};
            ge = (trial >= {1'b0, s_den});
            rem_next[k] = ge ? DEN_W'(trial - {1'b0, s_den}) : DEN_W'(trial);
            nq_next[k]  = {s_nq[NUM_W-2:0], ge};
            den_next[k] = s_den;
            tag_next[k] = s_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_W; k++)
            begin
                tag_reg[k] <= '0;
            end
            out_tag_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_W; k++)
            begin
                tag_reg[k] <= tag_next[k];
            end
            out_tag_reg <= tag_reg[NUM_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_W; k++)
        begin
            rem_reg[k] <= rem_next[k];
            nq_reg[k]  <= nq_next[k];
            den_reg[k] <= den_next[k];
        end
        if (tag_reg[NUM_W-1].neg)
        begin
            quo_reg <= -$signed({1'b0, nq_reg[NUM_W-1]});
        end
        else
        begin
            quo_reg <= $signed({1'b0, nq_reg[NUM_W-1]});
        end
    end

    assign out_tag = out_tag_reg;
    assign quo     = quo_reg;

endmodule

/* rtl/core/ray_aabb_slab_intersect_2d.sv */
// Top level of the 2D ray versus axis-aligned box slab test.
// Depends on rasi_pkg and rasi_div_pipe.
//
// One item (ray and box) enters in every cycle; busy is always low, and the result of
// each item appears on done for one cycle once it has passed the four slab divisions,
// which resolve one quotient bit per pipeline stage. The receiver cannot stall.
module ray_aabb_slab_intersect_2d
    import rasi_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] box_lo_x,
    input  logic signed [COORD_WIDTH-1:0] box_lo_y,
    input  logic signed [COORD_WIDTH-1:0] box_hi_x,
    input  logic signed [COORD_WIDTH-1:0] box_hi_y,
    output logic                          done,
    output logic                          hit,
    output logic [COORD_WIDTH-2:0]        entry_param,
    output logic signed [COORD_WIDTH-1:0] hit_x,
    output logic signed [COORD_WIDTH-1:0] hit_y
);

    localparam int W       = COORD_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int NW      = W + 1 + F;
    localparam int QS      = NW + 1;
    localparam int DIV_LAT = NW + 1;
    localparam int TLO     = (NW + 1) / 2;
    localparam int THI     = NW - TLO;
    localparam int PW      = NW + W;
    localparam int SH      = PW + 1 - F;
    localparam int SHW     = SH + 1;
    localparam int LAT     = NW + 9;

    typedef struct packed {
        logic signed [W-1:0] sx;
        logic signed [W-1:0] sy;
        logic                dx_neg;
        logic                dy_neg;
        logic [W-1:0]        dx_mag;
        logic [W-1:0]        dy_mag;
        logic                par_x;
        logic                par_y;
        logic                in_x;
        logic                in_y;
    } side_t;

    // Input capture.
    logic                v0_reg;
    logic signed [W-1:0] sx0_reg, sy0_reg, dx0_reg, dy0_reg;
    logic signed [W-1:0] lx0_reg, ly0_reg, hx0_reg, hy0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sx0_reg <= start_x;
            sy0_reg <= start_y;
            dx0_reg <= dir_x;
            dy0_reg <= dir_y;
            lx0_reg <= box_lo_x;
            ly0_reg <= box_lo_y;
            hx0_reg <= box_hi_x;
            hy0_reg <= box_hi_y;
        end
    end

    // Plane offsets, magnitudes and signs.
    logic signed [W:0] dlx, dhx, dly, dhy;
    logic [W:0]        mlx, mhx, mly, mhy;
    side_t             side1_next;

    always_comb
    begin
        dlx = $signed({lx0_reg[W-1], lx0_reg}) - $signed({sx0_reg[W-1], sx0_reg});
        dhx = $signed({hx0_reg[W-1], hx0_reg}) - $signed({sx0_reg[W-1], sx0_reg});
        dly = $signed({ly0_reg[W-1], ly0_reg}) - $signed({sy0_reg[W-1], sy0_reg});
        dhy = $signed({hy0_reg[W-1], hy0_reg}) - $signed({sy0_reg[W-1], sy0_reg});
        mlx = dlx[W] ? (~dlx) + (W+1)'(1) : dlx;
        mhx = dhx[W] ? (~dhx) + (W+1)'(1) : dhx;
        mly = dly[W] ? (~dly) + (W+1)'(1) : dly;
        mhy = dhy[W] ? (~dhy) + (W+1)'(1) : dhy;
        side1_next.sx     = sx0_reg;
        side1_next.sy     = sy0_reg;
        side1_next.dx_neg = dx0_reg[W-1];
        side1_next.dy_neg = dy0_reg[W-1];
        side1_next.dx_mag = dx0_reg[W-1] ? (~dx0_reg) + W'(1) : dx0_reg;
        side1_next.dy_mag = dy0_reg[W-1] ? (~dy0_reg) + W'(1) : dy0_reg;
        side1_next.par_x  = (dx0_reg == '0);
        side1_next.par_y  = (dy0_reg == '0);
        side1_next.in_x   = !(sx0_reg < lx0_reg) && !(sx0_reg > hx0_reg);
        side1_next.in_y   = !(sy0_reg < ly0_reg) && !(sy0_reg > hy0_reg);
    end

    side_t           side1_reg;
    div_tag_t        tlx1_reg, thx1_reg, tly1_reg, thy1_reg;
    logic [NW-1:0]   nlx1_reg, nhx1_reg, nly1_reg, nhy1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlx1_reg <= '0;
            thx1_reg <= '0;
            tly1_reg <= '0;
            thy1_reg <= '0;
        end
        else
        begin
            tlx1_reg <= '{valid: v0_reg, neg: dlx[W] ^ dx0_reg[W-1]};
            thx1_reg <= '{valid: v0_reg, neg: dhx[W] ^ dx0_reg[W-1]};
            tly1_reg <= '{valid: v0_reg, neg: dly[W] ^ dy0_reg[W-1]};
            thy1_reg <= '{valid: v0_reg, neg: dhy[W] ^ dy0_reg[W-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= side1_next;
        nlx1_reg  <= {mlx, {F{1'b0}}};
        nhx1_reg  <= {mhx, {F{1'b0}}};
        nly1_reg  <= {mly, {F{1'b0}}};
        nhy1_reg  <= {mhy, {F{1'b0}}};
    end

    // Slab divisions.
    div_tag_t               tlx, thx, tly, thy;
    logic signed [QS-1:0]   qlx, qhx, qly, qhy;

    rasi_div_pipe #(.NUM_W(NW), .DEN_W(W)) u_div_lx
    (
        .clk(clk), .rst_n(rst_n), .in_tag(tlx1_reg), .num(nlx1_reg),
        .den(side1_reg.dx_mag), .out_tag(tlx), .quo(qlx)
    );

    rasi_div_pipe #(.NUM_W(NW), .DEN_W(W)) u_div_hx
    (
        .clk(clk), .rst_n(rst_n), .in_tag(thx1_reg), .num(nhx1_reg),
        .den(side1_reg.dx_mag), .out_tag(thx), .quo(qhx)
    );

    rasi_div_pipe #(.NUM_W(NW), .DEN_W(W)) u_div_ly
    (
        .clk(clk), .rst_n(rst_n), .in_tag(tly1_reg), .num(nly1_reg),
        .den(side1_reg.dy_mag), .out_tag(tly), .quo(qly)
    );

    rasi_div_pipe #(.NUM_W(NW), .DEN_W(W)) u_div_hy
    (
        .clk(clk), .rst_n(rst_n), .in_tag(thy1_reg), .num(nhy1_reg),
        .den(side1_reg.dy_mag), .out_tag(thy), .quo(qhy)
    );

    side_t side_d_reg [DIV_LAT];

    always_ff @(posedge clk)
    begin
        side_d_reg[0] <= side1_reg;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            side_d_reg[i] <= side_d_reg[i-1];
        end
    end

    // Near and far planes per axis.
    logic                 va;
    side_t                sidea;
    logic signed [QS-1:0] nx, fx, ny, fy;

    always_comb
    begin
        va    = tlx.valid & thx.valid & tly.valid & thy.valid;
        sidea = side_d_reg[DIV_LAT-1];
        nx    = (qlx > qhx) ? qhx : qlx;
        fx    = (qlx > qhx) ? qlx : qhx;
        ny    = (qly > qhy) ? qhy : qly;
        fy    = (qly > qhy) ? qly : qhy;
    end

    logic                 vb_reg;
    side_t                sideb_reg;
    logic signed [QS-1:0] entxb_reg, fxb_reg, nyb_reg, fyb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= va;
        end
    end

    always_ff @(posedge clk)
    begin
        sideb_reg <= sidea;
        entxb_reg <= (sidea.par_x || nx[QS-1]) ? '0 : nx;
        fxb_reg   <= fx;
        nyb_reg   <= ny;
        fyb_reg   <= fy;
    end

    // Interval overlap and entry parameter.
    logic                 okx, oky;
    logic signed [QS-1:0] entyb, tqb;

    always_comb
    begin
        okx   = sideb_reg.par_x ? sideb_reg.in_x : !(entxb_reg > fxb_reg);
        oky   = sideb_reg.par_y ? sideb_reg.in_y
                : (!(entxb_reg > fyb_reg) && (sideb_reg.par_x || !(nyb_reg > fxb_reg)));
        entyb = sideb_reg.par_y ? '0 : nyb_reg;
        tqb   = (entxb_reg >= entyb) ? entxb_reg : entyb;
    end

    logic          vc_reg, mc_reg;
    side_t         sidec_reg;
    logic [NW-1:0] tqc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else
        begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sidec_reg <= sideb_reg;
        mc_reg    <= okx && oky;
        tqc_reg   <= tqb[NW-1:0];
    end

    // Partial products of t and the direction magnitudes.
    logic               vd_reg, md_reg;
    side_t              sided_reg;
    logic [W-2:0]       epd_reg;
    logic [TLO+W-1:0]   plx_reg, ply_reg;
    logic [THI+W-1:0]   phx_reg, phy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
        end
        else
        begin
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sided_reg <= sidec_reg;
        md_reg    <= mc_reg;
        epd_reg   <= (tqc_reg[NW-1:W-1] != '0) ? '1 : tqc_reg[W-2:0];
        plx_reg   <= (TLO+W)'(tqc_reg[TLO-1:0]) * (TLO+W)'(sidec_reg.dx_mag);
        ply_reg   <= (TLO+W)'(tqc_reg[TLO-1:0]) * (TLO+W)'(sidec_reg.dy_mag);
        phx_reg   <= (THI+W)'(tqc_reg[NW-1:TLO]) * (THI+W)'(sidec_reg.dx_mag);
        phy_reg   <= (THI+W)'(tqc_reg[NW-1:TLO]) * (THI+W)'(sidec_reg.dy_mag);
    end

    // Full products.
    logic          ve_reg, me_reg;
    side_t         sidee_reg;
    logic [W-2:0]  epe_reg;
    logic [PW-1:0] prx_reg, pry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
        end
        else
        begin
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sidee_reg <= sided_reg;
        me_reg    <= md_reg;
        epe_reg   <= epd_reg;
        prx_reg   <= PW'(plx_reg) + (PW'(phx_reg) << TLO);
        pry_reg   <= PW'(ply_reg) + (PW'(phy_reg) << TLO);
    end

    // Signed product, scaled back by the fraction width with floor rounding.
    logic signed [PW:0] spx, spy;

    always_comb
    begin
        spx = sidee_reg.dx_neg ? -$signed({1'b0, prx_reg}) : $signed({1'b0, prx_reg});
        spy = sidee_reg.dy_neg ? -$signed({1'b0, pry_reg}) : $signed({1'b0, pry_reg});
    end

    logic                 vf_reg, mf_reg;
    side_t                sidef_reg;
    logic [W-2:0]         epf_reg;
    logic signed [SH-1:0] shx_reg, shy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
        end
        else
        begin
            vf_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sidef_reg <= sidee_reg;
        mf_reg    <= me_reg;
        epf_reg   <= epe_reg;
        shx_reg   <= spx[PW:F];
        shy_reg   <= spy[PW:F];
    end

    // Entry point and saturation.
    logic signed [SHW-1:0] hx, hy;
    logic [W-1:0]          satx, saty;

    always_comb
    begin
        hx = $signed({shx_reg[SH-1], shx_reg}) + SHW'(sidef_reg.sx);
        hy = $signed({shy_reg[SH-1], shy_reg}) + SHW'(sidef_reg.sy);
        if ((&hx[SHW-1:W-1]) || !(|hx[SHW-1:W-1]))
        begin
            satx = hx[W-1:0];
        end
        else
        begin
            satx = hx[SHW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        if ((&hy[SHW-1:W-1]) || !(|hy[SHW-1:W-1]))
        begin
            saty = hy[W-1:0];
        end
        else
        begin
            saty = hy[SHW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    end

    logic                done_reg, hit_reg;
    logic [W-2:0]        ep_reg;
    logic signed [W-1:0] hx_reg, hy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= mf_reg;
        ep_reg  <= mf_reg ? epf_reg : '0;
        hx_reg  <= mf_reg ? $signed(satx) : '0;
        hy_reg  <= mf_reg ? $signed(saty) : '0;
    end

    assign busy        = 1'b0;
    assign done        = done_reg;
    assign hit         = hit_reg;
    assign entry_param = ep_reg;
    assign hit_x       = hx_reg;
    assign hit_y       = hy_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("Accepted item produced no result at the pipeline latency.");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> entry_param == '0 && hit_x == '0 && hit_y == '0)
        else $error("Missed item carries nonzero result fields.");

    a_inside_start: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit && entry_param == '0 |->
            hit_x == $past(start_x, LAT) && hit_y == $past(start_y, LAT))
        else $error("Entry at zero parameter is not the ray start.");

endmodule
